// ----- hdl/stack_bytecode_executor_defines.svh -----
// Shared assertion macros for the stack executor.
`ifndef STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SBE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SBE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sbe_pkg.sv -----
`timescale 1ns / 1ps

package sbe_pkg;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'd0,
        OP_STORE = 4'd1,
        OP_CONST = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MUL   = 4'd5,
        OP_LT    = 4'd6,
        OP_GT    = 4'd7,
        OP_AND   = 4'd8,
        OP_OR    = 4'd9,
        OP_NOT   = 4'd10,
        OP_EQ    = 4'd11,
        OP_PRINT = 4'd12
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned VIDX_W   = 4;
    localparam int unsigned DEPTH_W  = 5;

    // Operands of a two-operand instruction: a is next-on-stack, b is top.
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
    } alu_req_t;

endpackage

// ----- hdl/sbe_alu.sv -----
`timescale 1ns / 1ps

module sbe_alu
    import sbe_pkg::*;
(
    input  alu_req_t          req,
    output logic [DATA_W-1:0] result
);

    logic a_nz;
    logic b_nz;

    assign a_nz = (req.a != '0);
    assign b_nz = (req.b != '0);

    always_comb begin
        case (req.op)
            OP_ADD:  result = req.a + req.b;
            OP_SUB:  result = req.a - req.b;
            OP_MUL:  result = req.a * req.b;
            OP_LT:   result = DATA_W'($signed(req.a) < $signed(req.b));
            OP_GT:   result = DATA_W'($signed(req.b) < $signed(req.a));
            OP_AND:  result = DATA_W'(a_nz && b_nz);
            OP_OR:   result = DATA_W'(a_nz || b_nz);
            default: result = DATA_W'(req.a == req.b);
        endcase
    end

endmodule

// ----- hdl/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
// Channel  | ports                                              | dir
// ---------+----------------------------------------------------+-----
// input    | s_valid s_ready s_opcode s_var_index s_immediate   | in
// result   | m_valid m_ready m_print_valid m_print_value        | out
//          | m_status m_stack_depth                             |
//
// One instruction word per cycle sustained while the result side does not stall;
// each accepted word yields one result word, through the variable read stage and
// then execute into the output register. The variable memory's registered read
// is why there is a read stage; execute, including the 32x32 multiply, is combinational.
// Reset clears the stack pointer and the variable valid bits; there is no
// clearing pass. A stall on the result side holds the output register, then
// the execute stage, then drops s_ready.

module stack_bytecode_executor
    import sbe_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned VAR_COUNT   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OPCODE_W-1:0]     s_opcode,
    input  logic [VIDX_W-1:0]       s_var_index,
    input  logic signed [DATA_W-1:0] s_immediate,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_print_valid,
    output logic signed [DATA_W-1:0] m_print_value,
    output logic [1:0]              m_status,
    output logic [DEPTH_W-1:0]      m_stack_depth
);

`include "stack_bytecode_executor_defines.svh"

    // Stack pointer counts 0..STACK_DEPTH; spill memory addresses need fewer bits.
    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned VW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int unsigned CW  = 9;  // wide enough to compare against VAR_COUNT

    // ---------------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------------
    logic ex_valid_reg;
    logic ex_fire;
    logic s_accept;
    logic m_valid_reg;

    assign ex_fire  = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !ex_valid_reg || ex_fire;
    assign s_accept = s_valid && s_ready;

    // ---------------------------------------------------------------------
    // Read stage: latch the instruction word and read the variable memory
    // ---------------------------------------------------------------------
    logic [OPCODE_W-1:0] ex_op_reg;
    logic [VW-1:0]       ex_vaddr_reg;
    logic                ex_idx_ok_reg;
    logic [DATA_W-1:0]   ex_imm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_accept) begin
            ex_valid_reg <= 1'b1;
        end else if (ex_fire) begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_op_reg     <= s_opcode;
            ex_vaddr_reg  <= VW'(s_var_index);
            ex_idx_ok_reg <= (CW'(s_var_index) < CW'(VAR_COUNT));
            ex_imm_reg    <= s_immediate;
        end
    end

    // Variable memory with one valid bit per entry; an unwritten entry reads zero.
    logic [DATA_W-1:0]    var_mem [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_vld_reg;
    logic                 var_we;
    logic [VW-1:0]        var_raddr;
    logic                 var_hit;
    logic [DATA_W-1:0]    var_rd_reg;
    logic                 var_rd_ok_reg;
    logic [DATA_W-1:0]    store_data;

    assign var_raddr = VW'(s_var_index);
    // A store leaving execute in the same cycle as a load is read: forward it.
    assign var_hit   = var_we && (ex_vaddr_reg == var_raddr);

    always_ff @(posedge aclk) begin
        if (var_we) begin
            var_mem[ex_vaddr_reg] <= store_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_vld_reg <= '0;
        end else if (var_we) begin
            var_vld_reg[ex_vaddr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            var_rd_reg    <= var_hit ? store_data : var_mem[var_raddr];
            var_rd_ok_reg <= var_hit || var_vld_reg[var_raddr];
        end
    end

    // ---------------------------------------------------------------------
    // Operand stack: top two entries in registers, the rest in a memory.
    // third_reg always holds entry sp-3 for the current stack pointer.
    // ---------------------------------------------------------------------
    logic [SPW-1:0]    sp_reg;
    logic [SPW-1:0]    sp_next;
    logic [DATA_W-1:0] tos_reg;
    logic [DATA_W-1:0] tos_next;
    logic [DATA_W-1:0] nos_reg;
    logic [DATA_W-1:0] nos_next;
    logic [DATA_W-1:0] third_reg;

    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
    logic              stk_we;
    logic [AW-1:0]     stk_waddr;
    logic [AW-1:0]     stk_raddr;

    assign stk_waddr = AW'(sp_reg - SPW'(2));
    assign stk_raddr = AW'(sp_next - SPW'(3));

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= nos_reg;
        end
    end

    // Forward the spill write when the new pointer reads the entry just pushed.
    always_ff @(posedge aclk) begin
        third_reg <= (stk_we && (stk_waddr == stk_raddr)) ? nos_reg : stk_mem[stk_raddr];
    end

    // ---------------------------------------------------------------------
    // Execute
    // ---------------------------------------------------------------------
    alu_req_t          alu_req;
    logic [DATA_W-1:0] alu_result;

    assign alu_req = '{op: ex_op_reg, a: nos_reg, b: tos_reg};

    sbe_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    logic              empty;
    logic              short;
    logic              full;
    logic [DATA_W-1:0] push_val;
    logic              pv_next;
    logic [DATA_W-1:0] pval_next;
    status_t           status_next;

    assign empty      = (sp_reg == '0);
    assign short      = (sp_reg < SPW'(2));
    assign full       = (sp_reg == SPW'(STACK_DEPTH));
    assign store_data = tos_reg;
    assign push_val   = (ex_op_reg == OP_CONST) ? ex_imm_reg :
                        (ex_idx_ok_reg && var_rd_ok_reg) ? var_rd_reg : '0;

    always_comb begin
        sp_next     = sp_reg;
        tos_next    = tos_reg;
        nos_next    = nos_reg;
        stk_we      = 1'b0;
        var_we      = 1'b0;
        pv_next     = 1'b0;
        pval_next   = '0;
        status_next = ST_OK;
        if (ex_fire) begin
            case (ex_op_reg)
                OP_LOAD, OP_CONST: begin
                    if (full) begin
                        status_next = ST_OVER;
                    end else begin
                        stk_we   = !short;
                        nos_next = tos_reg;
                        tos_next = push_val;
                        sp_next  = sp_reg + SPW'(1);
                    end
                end
                OP_STORE, OP_PRINT: begin
                    if (empty) begin
                        status_next = ST_UNDER;
                    end else begin
                        tos_next = nos_reg;
                        nos_next = third_reg;
                        sp_next  = sp_reg - SPW'(1);
                        if (ex_op_reg == OP_STORE) begin
                            var_we = ex_idx_ok_reg;
                        end else begin
                            pv_next   = 1'b1;
                            pval_next = tos_reg;
                        end
                    end
                end
                OP_NOT: begin
                    if (empty) begin
                        status_next = ST_UNDER;
                    end else begin
                        tos_next = DATA_W'(tos_reg == '0);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_AND, OP_OR, OP_EQ: begin
                    if (short) begin
                        status_next = ST_UNDER;
                    end else begin
                        tos_next = alu_result;
                        nos_next = third_reg;
                        sp_next  = sp_reg - SPW'(1);
                    end
                end
                default: begin
                    // unused opcode: no effect, status ok
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        nos_reg <= nos_next;
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    logic                m_print_valid_reg;
    logic [DATA_W-1:0]   m_print_value_reg;
    logic [1:0]          m_status_reg;
    logic [DEPTH_W-1:0]  m_stack_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ex_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            m_print_valid_reg <= pv_next;
            m_print_value_reg <= pval_next;
            m_status_reg      <= status_next;
            m_stack_depth_reg <= DEPTH_W'(sp_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_print_valid = m_print_valid_reg;
    assign m_print_value = m_print_value_reg;
    assign m_status      = m_status_reg;
    assign m_stack_depth = m_stack_depth_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `SBE_ASSERT_NOW(a_sp_bound, aclk, aresetn, 1'b1, sp_reg <= SPW'(STACK_DEPTH), "stack pointer past depth")

    `SBE_ASSERT_NOW(a_print_ok, aclk, aresetn, m_valid_reg && m_print_valid_reg, m_status_reg == ST_OK, "print word flagged with error status")

    `SBE_ASSERT_NEXT(a_err_hold, aclk, aresetn, ex_fire && (status_next != ST_OK), sp_reg == $past(sp_reg), "faulted instruction moved the stack")

    `SBE_ASSERT_NEXT(a_ex_hold, aclk, aresetn, ex_valid_reg && !ex_fire, ex_valid_reg && $stable(ex_op_reg), "stalled instruction lost")

endmodule
